@@ hdl/tcr_pkg.sv @@
// ----------------------------------------------------------------------------
// tcr_pkg
// Shared constants and types for the triangle coverage rasterizer.
// ----------------------------------------------------------------------------
package tcr_pkg;

    localparam int GRID_SIZE_DEF = 1024;

    localparam int IN_W  = 10;          // corner coordinate field width
    localparam int CFG_W = 11;          // configuration register width
    localparam int CFG_IDX_W = 2;
    localparam int CMD_W = 2;
    localparam int CNT_W = 21;          // tally result width
    localparam int PIX_W = 8;           // coverage counter width

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RASTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TALLY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] CFG_SIZE_RST = 11'd1024;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

    // edge walker request
    typedef struct packed {
        logic start;
        logic to_left;
    } walk_cmd_t;

    // edge table write selects
    typedef struct packed {
        logic left;
        logic right;
    } edge_wr_t;

endpackage

@@ hdl/tcr_ram.sv @@
// ----------------------------------------------------------------------------
// tcr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/tcr_edge_walk.sv @@
// ----------------------------------------------------------------------------
// tcr_edge_walk
// Bresenham edge walker: one step per cycle, writes one column per row
// into the left or right edge table.
// ----------------------------------------------------------------------------
module tcr_edge_walk
    import tcr_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  walk_cmd_t                    cmd,
    input  logic [$clog2(GRID_SIZE)-1:0] x1,
    input  logic [$clog2(GRID_SIZE)-1:0] y1,
    input  logic [$clog2(GRID_SIZE)-1:0] x2,
    input  logic [$clog2(GRID_SIZE)-1:0] y2,
    output edge_wr_t                     wr,
    output logic [$clog2(GRID_SIZE)-1:0] wr_addr,
    output logic [$clog2(GRID_SIZE)-1:0] wr_data,
    output logic                         done
);

    localparam int CW = $clog2(GRID_SIZE);
    localparam int EW = CW + 4;

    localparam logic [1:0] W_IDLE  = 2'd0;
    localparam logic [1:0] W_SETUP = 2'd1;
    localparam logic [1:0] W_ROW   = 2'd2;
    localparam logic [1:0] W_X     = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic                left_reg, left_next;
    logic [CW-1:0]       xa_reg, xa_next, ya_reg, ya_next;
    logic [CW-1:0]       xb_reg, xb_next, yb_reg, yb_next;
    logic [CW-1:0]       px_reg, px_next, py_reg, py_next;
    logic [CW-1:0]       adx_reg, adx_next, dy_reg, dy_next;
    logic                sxp_reg, sxp_next;
    logic signed [EW-1:0] err_reg, err_next;

    logic signed [CW:0]  dx;
    logic [CW-1:0]       adx;
    logic [CW-1:0]       dy;
    logic                wen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        xa_reg   <= xa_next;
        ya_reg   <= ya_next;
        xb_reg   <= xb_next;
        yb_reg   <= yb_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        adx_reg  <= adx_next;
        dy_reg   <= dy_next;
        sxp_reg  <= sxp_next;
        err_reg  <= err_next;
    end

    assign dx  = $signed({1'b0, xb_reg}) - $signed({1'b0, xa_reg});
    assign adx = (dx > 0) ? CW'(dx) : CW'(-dx);
    assign dy  = yb_reg - ya_reg;

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        xa_next    = xa_reg;
        ya_next    = ya_reg;
        xb_next    = xb_reg;
        yb_next    = yb_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        adx_next   = adx_reg;
        dy_next    = dy_reg;
        sxp_next   = sxp_reg;
        err_next   = err_reg;
        wen        = 1'b0;
        wr_addr    = py_reg;
        wr_data    = px_reg;
        done       = 1'b0;

        unique case (state_reg)
            W_IDLE:
            begin
                if (cmd.start)
                begin
                    left_next = cmd.to_left;
                    // walk always goes downward in row
                    if (y1 > y2)
                    begin
                        xa_next = x2;
                        ya_next = y2;
                        xb_next = x1;
                        yb_next = y1;
                    end
                    else
                    begin
                        xa_next = x1;
                        ya_next = y1;
                        xb_next = x2;
                        yb_next = y2;
                    end
                    state_next = W_SETUP;
                end
            end
            W_SETUP:
            begin
                adx_next = adx;
                dy_next  = dy;
                sxp_next = (dx > 0);
                err_next = $signed(EW'(dy)) - $signed(EW'({adx, 1'b0}));
                px_next  = xa_reg;
                py_next  = ya_reg;
                wen      = 1'b1;
                wr_addr  = ya_reg;
                wr_data  = xa_reg;
                state_next = W_ROW;
            end
            W_ROW:
            begin
                if ((CW+1)'(py_reg) + (CW+1)'(1) < (CW+1)'(yb_reg))
                begin
                    py_next  = py_reg + CW'(1);
                    err_next = err_reg - $signed(EW'({adx_reg, 1'b0}));
                    state_next = W_X;
                end
                else
                begin
                    wen     = 1'b1;
                    wr_addr = yb_reg;
                    wr_data = xb_reg;
                    done    = 1'b1;
                    state_next = W_IDLE;
                end
            end
            W_X:
            begin
                if (err_reg < 0)
                begin
                    px_next  = sxp_reg ? px_reg + CW'(1) : px_reg - CW'(1);
                    err_next = err_reg + $signed(EW'({dy_reg, 1'b0}));
                end
                else
                begin
                    wen = 1'b1;
                    state_next = W_ROW;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    assign wr.left  = wen & left_reg;
    assign wr.right = wen & ~left_reg;

endmodule

@@ hdl/triangle_coverage_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// triangle_coverage_rasterizer_unit
// Coverage grid with clear, triangle rasterize and coverage tally commands.
// ----------------------------------------------------------------------------
// One command is worked at a time; in_ready is low while it runs and while a
// tally result waits on the output. After reset, and for each clear, the
// grid is swept one counter a cycle, all GRID_SIZE*GRID_SIZE counters (1M
// at the default size), before the next beat is taken. A rasterize runs
// setup states S_AREA1 to S_AREA3 (two area products through one shared
// multiplier, then their compare; a triangle flat in y ends after S_AREA2),
// then the edge walker for each non-flat edge, skipping flat edges, then
// per covered row an edge table read and a read-modify-write of each pixel
// in the coverage RAM. A tally reads the active_width by active_height
// window, one counter read per cycle.
// ----------------------------------------------------------------------------
module triangle_coverage_rasterizer_unit
    import tcr_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [IN_W-1:0]      ax,
    input  logic [IN_W-1:0]      ay,
    input  logic [IN_W-1:0]      bx,
    input  logic [IN_W-1:0]      by_row,
    input  logic [IN_W-1:0]      cx,
    input  logic [IN_W-1:0]      cy,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CNT_W-1:0]     filled_count,
    output logic [CNT_W-1:0]     overlapped_count,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CW   = $clog2(GRID_SIZE);
    localparam int NPIX = GRID_SIZE * GRID_SIZE;
    localparam int AW   = $clog2(NPIX);
    localparam int XW   = IN_W + CW;
    localparam int TW   = (CFG_W > CW + 1) ? CFG_W : CW + 1;
    localparam int PW   = 2 * (CW + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_AREA1  = 4'd2;
    localparam logic [3:0] S_AREA2  = 4'd3;
    localparam logic [3:0] S_AREA3  = 4'd4;
    localparam logic [3:0] S_EDGE   = 4'd5;
    localparam logic [3:0] S_EWAIT  = 4'd6;
    localparam logic [3:0] S_ROW    = 4'd7;
    localparam logic [3:0] S_ROWRD  = 4'd8;
    localparam logic [3:0] S_PIX    = 4'd9;
    localparam logic [3:0] S_PIXWR  = 4'd10;
    localparam logic [3:0] S_TRD    = 4'd11;
    localparam logic [3:0] S_TDRAIN = 4'd12;
    localparam logic [3:0] S_TOUT   = 4'd13;

    function automatic logic [CW-1:0] clamp_c(input logic [IN_W-1:0] v);
        if (XW'(v) > XW'(GRID_SIZE - 1))
            return CW'(GRID_SIZE - 1);
        else
            return CW'(v);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    logic [3:0]         state_reg, state_next;
    logic [CFG_W-1:0]   width_reg, width_next, height_reg, height_next;
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   fill_reg, fill_next, over_reg, over_next;
    logic               pend_reg, pend_next;

    logic [CW-1:0]      xs_reg [3];
    logic [CW-1:0]      xs_next [3];
    logic [CW-1:0]      ys_reg [3];
    logic [CW-1:0]      ys_next [3];
    logic [CW-1:0]      ymin_reg, ymin_next, ymax_reg, ymax_next;
    logic signed [PW-1:0] p1_reg, p1_next, p2_reg, p2_next;
    logic               ccw_reg, ccw_next;
    logic [1:0]         eidx_reg, eidx_next;

    logic [CW-1:0]      row_reg, row_next, col_reg, col_next;
    logic [CW-1:0]      right_reg, right_next;
    logic [CW-1:0]      wlast_reg, wlast_next, hlast_reg, hlast_next;
    logic [AW-1:0]      base_reg, base_next, addr_reg, addr_next;

    logic               in_fire;
    logic [TW-1:0]      wlim, hlim;
    logic [AW-1:0]      pix_addr;
    logic signed [CW:0] mul_a, mul_b;
    logic [1:0]         ek;
    logic [CW-1:0]      ex1, ey1, ex2, ey2;

    walk_cmd_t          wcmd;
    edge_wr_t           ewr;
    logic [CW-1:0]      ew_addr, ew_data;
    logic               w_done;
    logic [CW-1:0]      left_q, right_q;

    logic               cov_we;
    logic [AW-1:0]      cov_waddr;
    logic [PIX_W-1:0]   cov_wdata, cov_q;

    assign in_ready         = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_fire          = in_valid && in_ready;
    assign out_valid        = out_valid_reg;
    assign filled_count     = fill_reg;
    assign overlapped_count = over_reg;

    assign wlim = (TW'(width_reg) > TW'(GRID_SIZE)) ? TW'(GRID_SIZE) : TW'(width_reg);
    assign hlim = (TW'(height_reg) > TW'(GRID_SIZE)) ? TW'(GRID_SIZE) : TW'(height_reg);
    assign pix_addr = base_reg + AW'(col_reg);

    // shared multiplier operands for the two area products
    always_comb
    begin
        if (state_reg == S_AREA1)
        begin
            mul_a = $signed({1'b0, xs_reg[1]}) - $signed({1'b0, xs_reg[0]});
            mul_b = $signed({1'b0, ys_reg[2]}) - $signed({1'b0, ys_reg[0]});
        end
        else
        begin
            mul_a = $signed({1'b0, xs_reg[2]}) - $signed({1'b0, xs_reg[0]});
            mul_b = $signed({1'b0, ys_reg[1]}) - $signed({1'b0, ys_reg[0]});
        end
    end

    assign ek  = (eidx_reg == 2'd2) ? 2'd0 : eidx_reg + 2'd1;
    assign ex1 = xs_reg[eidx_reg];
    assign ey1 = ys_reg[eidx_reg];
    assign ex2 = xs_reg[ek];
    assign ey2 = ys_reg[ek];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            width_reg     <= CFG_SIZE_RST;
            height_reg    <= CFG_SIZE_RST;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            addr_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            addr_reg      <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg  <= fill_next;
        over_reg  <= over_next;
        xs_reg    <= xs_next;
        ys_reg    <= ys_next;
        ymin_reg  <= ymin_next;
        ymax_reg  <= ymax_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        ccw_reg   <= ccw_next;
        eidx_reg  <= eidx_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        right_reg <= right_next;
        wlast_reg <= wlast_next;
        hlast_reg <= hlast_next;
        base_reg  <= base_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        out_valid_next = out_valid_reg;
        fill_next      = fill_reg;
        over_next      = over_reg;
        pend_next      = 1'b0;
        xs_next        = xs_reg;
        ys_next        = ys_reg;
        ymin_next      = ymin_reg;
        ymax_next      = ymax_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        ccw_next       = ccw_reg;
        eidx_next      = eidx_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        right_next     = right_reg;
        wlast_next     = wlast_reg;
        hlast_next     = hlast_reg;
        base_next      = base_reg;
        addr_next      = addr_reg;
        wcmd.start     = 1'b0;
        wcmd.to_left   = ((ey2 < ey1) != ccw_reg);
        cov_we         = 1'b0;
        cov_waddr      = addr_reg;
        cov_wdata      = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_WIDTH:  width_next = cfg_data;
                CFG_ACTIVE_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // tally accumulate on the read issued last cycle
        if (pend_reg)
        begin
            if (cov_q != '0)
                fill_next = sat_inc(fill_reg);
            if (cov_q > PIX_W'(1))
                over_next = sat_inc(over_reg);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = S_CLR;
                        end
                        CMD_RASTER:
                        begin
                            xs_next[0] = clamp_c(ax);
                            ys_next[0] = clamp_c(ay);
                            xs_next[1] = clamp_c(bx);
                            ys_next[1] = clamp_c(by_row);
                            xs_next[2] = clamp_c(cx);
                            ys_next[2] = clamp_c(cy);
                            state_next = S_AREA1;
                        end
                        CMD_TALLY:
                        begin
                            fill_next = '0;
                            over_next = '0;
                            if (wlim == '0 || hlim == '0)
                            begin
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                wlast_next = CW'(wlim - TW'(1));
                                hlast_next = CW'(hlim - TW'(1));
                                row_next   = '0;
                                col_next   = '0;
                                base_next  = '0;
                                state_next = S_TRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR:
            begin
                cov_we    = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == AW'(NPIX - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_AREA1:
            begin
                p1_next   = PW'(mul_a * mul_b);
                ymin_next = ys_reg[0];
                ymax_next = ys_reg[0];
                for (int i = 1; i < 3; i++)
                begin
                    if (ys_reg[i] < ymin_next)
                        ymin_next = ys_reg[i];
                    if (ys_reg[i] > ymax_next)
                        ymax_next = ys_reg[i];
                end
                state_next = S_AREA2;
            end
            S_AREA2:
            begin
                p2_next = PW'(mul_a * mul_b);
                // flat in y: nothing to draw
                state_next = (ymin_reg == ymax_reg) ? S_IDLE : S_AREA3;
            end
            S_AREA3:
            begin
                ccw_next   = (p1_reg < p2_reg);
                base_next  = AW'(AW'(ymin_reg) * AW'(GRID_SIZE));
                eidx_next  = '0;
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                if (eidx_reg == 2'd3)
                begin
                    row_next   = ymin_reg;
                    state_next = S_ROW;
                end
                else if (ey1 == ey2)
                begin
                    eidx_next = eidx_reg + 2'd1;
                end
                else
                begin
                    wcmd.start = 1'b1;
                    state_next = S_EWAIT;
                end
            end
            S_EWAIT:
            begin
                if (w_done)
                begin
                    eidx_next  = eidx_reg + 2'd1;
                    state_next = S_EDGE;
                end
            end
            S_ROW:
            begin
                // edge tables read at row_reg this cycle
                state_next = (row_reg == ymax_reg) ? S_IDLE : S_ROWRD;
            end
            S_ROWRD:
            begin
                col_next   = left_q;
                right_next = right_q;
                state_next = S_PIX;
            end
            S_PIX:
            begin
                if (col_reg < right_reg)
                begin
                    addr_next  = pix_addr;
                    state_next = S_PIXWR;
                end
                else
                begin
                    row_next   = row_reg + CW'(1);
                    base_next  = base_reg + AW'(GRID_SIZE);
                    state_next = S_ROW;
                end
            end
            S_PIXWR:
            begin
                cov_we     = 1'b1;
                cov_wdata  = (cov_q == PIX_MAX) ? PIX_MAX : cov_q + PIX_W'(1);
                col_next   = col_reg + CW'(1);
                state_next = S_PIX;
            end
            S_TRD:
            begin
                pend_next = 1'b1;
                if (col_reg == wlast_reg)
                begin
                    col_next = '0;
                    if (row_reg == hlast_reg)
                    begin
                        state_next = S_TDRAIN;
                    end
                    else
                    begin
                        row_next  = row_reg + CW'(1);
                        base_next = base_reg + AW'(GRID_SIZE);
                    end
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            S_TDRAIN:
            begin
                state_next = S_TOUT;
            end
            S_TOUT:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    tcr_edge_walk #(
        .GRID_SIZE (GRID_SIZE)
    ) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (wcmd),
        .x1      (ex1),
        .y1      (ey1),
        .x2      (ex2),
        .y2      (ey2),
        .wr      (ewr),
        .wr_addr (ew_addr),
        .wr_data (ew_data),
        .done    (w_done)
    );

    tcr_ram #(
        .WIDTH (CW),
        .DEPTH (GRID_SIZE)
    ) u_left_edge (
        .clk   (clk),
        .we    (ewr.left),
        .waddr (ew_addr),
        .wdata (ew_data),
        .raddr (row_reg),
        .rdata (left_q)
    );

    tcr_ram #(
        .WIDTH (CW),
        .DEPTH (GRID_SIZE)
    ) u_right_edge (
        .clk   (clk),
        .we    (ewr.right),
        .waddr (ew_addr),
        .wdata (ew_data),
        .raddr (row_reg),
        .rdata (right_q)
    );

    tcr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (NPIX)
    ) u_coverage (
        .clk   (clk),
        .we    (cov_we),
        .waddr (cov_waddr),
        .wdata (cov_wdata),
        .raddr (pix_addr),
        .rdata (cov_q)
    );

endmodule
